// ===== src/quaternion_vector_alu_unit_defines.svh =====
// Assertion helpers used by the checker of the quaternion ALU.
`ifndef QUATERNION_VECTOR_ALU_UNIT_DEFINES_SVH
`define QUATERNION_VECTOR_ALU_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define QVA_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define QVA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== src/qva_pkg.sv =====
package qva_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CMD_WIDTH  = 3;
    localparam int NUM_LANES  = 4;

    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + 2;

    // square root: radicand up to 2^(2W), root up to 2^W
    localparam int SQ_WIDTH   = 2 * DATA_WIDTH + 2;
    localparam int ROOT_WIDTH = DATA_WIDTH + 1;
    localparam int SQ_STEPS   = DATA_WIDTH + 1;

    // divider: quotient never exceeds 2^FRAC_BITS since root >= |component|
    localparam int NUM_WIDTH  = DATA_WIDTH + FRAC_BITS + 1;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int QUO_WIDTH  = FRAC_BITS + 2;
    localparam int REM2_WIDTH = NUM_WIDTH + 1;

    localparam int LANE_LAT = 3;
    localparam int NORM_LAT = SQ_STEPS + DIV_STEPS + 3;

    // magnitude at or below 1e-8 counts as zero
    localparam logic [SQ_WIDTH-1:0] ZERO_THRESH =
        SQ_WIDTH'((64'd1 << (2 * FRAC_BITS)) / 64'd10000000000000000);

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef data_t [NUM_LANES-1:0] quat_t;

    localparam data_t Q_ONE = data_t'(64'd1 << FRAC_BITS);

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_PRODUCT   = 3'd0,
        CMD_NORMALIZE = 3'd1,
        CMD_SCALE     = 3'd2,
        CMD_ADD       = 3'd3,
        CMD_CONJUGATE = 3'd4,
        CMD_CROSS     = 3'd5
    } cmd_t;

    // operands of one lane: sum over k of +/- x[k]*y[k], then round by FRAC_BITS
    typedef struct packed {
        data_t [NUM_LANES-1:0] x;
        data_t [NUM_LANES-1:0] y;
        logic  [NUM_LANES-1:0] neg;
    } lane_op_t;

    localparam logic [1:0] PROD_BI [NUM_LANES][NUM_LANES] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam logic PROD_NEG [NUM_LANES][NUM_LANES] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 1'b0}
    };

    // add, negate and pass-through go through the multiplier with y = 1.0,
    // which rounds exactly
    function automatic lane_op_t lane_op(input logic [CMD_WIDTH-1:0] cmd,
                                         input logic [1:0] lane,
                                         input quat_t a, input quat_t b,
                                         input data_t s);
        lane_op_t   op;
        logic [1:0] u;
        logic [1:0] v;
        op = '0;
        u  = (lane == 2'd3) ? 2'd1 : lane + 2'd1;
        v  = (u == 2'd3) ? 2'd1 : u + 2'd1;
        case (cmd_t'(cmd))
            CMD_PRODUCT: begin
                for (int k = 0; k < NUM_LANES; k++) begin
                    op.x[k]   = a[k];
                    op.y[k]   = b[PROD_BI[lane][k]];
                    op.neg[k] = PROD_NEG[lane][k];
                end
            end
            CMD_SCALE: begin
                op.x[0] = a[lane];
                op.y[0] = s;
            end
            CMD_ADD: begin
                op.x[0] = a[lane];
                op.y[0] = Q_ONE;
                op.x[1] = b[lane];
                op.y[1] = Q_ONE;
            end
            CMD_CONJUGATE: begin
                op.x[0]   = a[lane];
                op.y[0]   = Q_ONE;
                op.neg[0] = (lane != 2'd0);
            end
            CMD_CROSS: begin
                if (lane != 2'd0) begin
                    op.x[0]   = a[u];
                    op.y[0]   = b[v];
                    op.x[1]   = a[v];
                    op.y[1]   = b[u];
                    op.neg[1] = 1'b1;
                end
            end
            default: begin
                op = '0;
            end
        endcase
        return op;
    endfunction

endpackage

// ===== src/qva_op_if.sv =====
interface qva_op_if;
    import qva_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_WIDTH-1:0] cmd;
    data_t                a_w;
    data_t                a_x;
    data_t                a_y;
    data_t                a_z;
    data_t                b_w;
    data_t                b_x;
    data_t                b_y;
    data_t                b_z;
    data_t                scale_factor;

    modport source (
        output valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor,
        input  ready
    );
    modport sink (
        input  valid, cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scale_factor,
        output ready
    );
endinterface

// ===== src/qva_res_if.sv =====
interface qva_res_if;
    import qva_pkg::*;

    logic  valid;
    logic  ready;
    data_t r_w;
    data_t r_x;
    data_t r_y;
    data_t r_z;
    logic  overflow;

    modport source (
        output valid, r_w, r_x, r_y, r_z, overflow,
        input  ready
    );
    modport sink (
        input  valid, r_w, r_x, r_y, r_z, overflow,
        output ready
    );
endinterface

// ===== src/quaternion_vector_alu_unit.sv =====
// Quaternion and vector ALU, signed Q16.16. Fully pipelined: one beat is
// accepted per cycle and every operation is delayed to the same depth, so
// results leave in order. The depth is set by the normalize path: a
// 33-stage square root followed by a 17-stage divider per component, with
// four lanes doing the multiply-accumulate work of the other operations in
// parallel. When a finished result is not taken the whole pipeline holds and
// operand ready drops until the result beat moves.
module quaternion_vector_alu_unit (
    input  logic      clk,
    input  logic      rst_n,
    qva_op_if.sink    operand,
    qva_res_if.source result
);
    import qva_pkg::*;

    localparam int DLY_DEPTH = NORM_LAT - LANE_LAT;

    typedef struct packed {
        quat_t                r;
        logic [NUM_LANES-1:0] ov;
    } lane_res_t;

    logic                 en;
    logic [NORM_LAT:0]    vld_reg;
    logic [CMD_WIDTH-1:0] cmd_reg;
    quat_t                a_reg, b_reg;
    data_t                s_reg;
    logic [CMD_WIDTH-1:0] cmd_dly_reg [NORM_LAT];
    lane_op_t             lane_ops [NUM_LANES];
    data_t                lane_r   [NUM_LANES];
    logic                 lane_ov  [NUM_LANES];
    lane_res_t            lane_res;
    lane_res_t            lane_dly_reg [DLY_DEPTH];
    quat_t                norm_r;
    quat_t                res_reg, res_next;
    logic                 ov_reg, ov_next;
    logic                 out_valid_reg;

    assign en            = !out_valid_reg || result.ready;
    assign operand.ready = en;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        assign lane_ops[i] = lane_op(cmd_reg, 2'(i), a_reg, b_reg, s_reg);
        qva_lane u_lane (
            .clk (clk),
            .en  (en),
            .op  (lane_ops[i]),
            .r   (lane_r[i]),
            .ov  (lane_ov[i])
        );
    end

    qva_norm u_norm (
        .clk (clk),
        .en  (en),
        .a   (a_reg),
        .r   (norm_r)
    );

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_res.r[i]  = lane_r[i];
            lane_res.ov[i] = lane_ov[i];
        end
    end

    // merge: normalize comes from the root/divide path, all else from the lanes
    always_comb begin
        if (cmd_dly_reg[NORM_LAT-1] == CMD_NORMALIZE) begin
            res_next = norm_r;
            ov_next  = 1'b0;
        end else begin
            res_next = lane_dly_reg[DLY_DEPTH-1].r;
            ov_next  = |lane_dly_reg[DLY_DEPTH-1].ov;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[NORM_LAT-1:0], operand.valid};
            out_valid_reg <= vld_reg[NORM_LAT];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            cmd_reg <= operand.cmd;
            a_reg   <= {operand.a_z, operand.a_y, operand.a_x, operand.a_w};
            b_reg   <= {operand.b_z, operand.b_y, operand.b_x, operand.b_w};
            s_reg   <= operand.scale_factor;

            cmd_dly_reg[0] <= cmd_reg;
            for (int i = 1; i < NORM_LAT; i++) begin
                cmd_dly_reg[i] <= cmd_dly_reg[i-1];
            end
            lane_dly_reg[0] <= lane_res;
            for (int i = 1; i < DLY_DEPTH; i++) begin
                lane_dly_reg[i] <= lane_dly_reg[i-1];
            end

            res_reg <= res_next;
            ov_reg  <= ov_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.r_w      = res_reg[0];
    assign result.r_x      = res_reg[1];
    assign result.r_y      = res_reg[2];
    assign result.r_z      = res_reg[3];
    assign result.overflow = ov_reg;

endmodule

// ===== src/qva_lane.sv =====
module qva_lane (
    input  logic              clk,
    input  logic              en,
    input  qva_pkg::lane_op_t op,
    output qva_pkg::data_t    r,
    output logic              ov
);
    import qva_pkg::*;

    localparam logic signed [ACC_WIDTH-1:0] HALF    = ACC_WIDTH'(1) << (FRAC_BITS - 1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_MAX = (ACC_WIDTH'(1) << (DATA_WIDTH - 1)) - 1;
    localparam logic signed [ACC_WIDTH-1:0] SAT_MIN = ~SAT_MAX;

    logic signed [PROD_WIDTH-1:0] prod_reg  [NUM_LANES];
    logic signed [PROD_WIDTH-1:0] prod_next [NUM_LANES];
    logic [NUM_LANES-1:0]         neg_reg;
    logic signed [ACC_WIDTH-1:0]  acc_reg, acc_next;
    data_t                        r_reg, r_next;
    logic                         ov_reg, ov_next;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            prod_next[k] = $signed(op.x[k]) * $signed(op.y[k]);
        end
    end

    always_comb begin
        logic signed [ACC_WIDTH-1:0] term;
        acc_next = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            term     = ACC_WIDTH'(prod_reg[k]);
            acc_next = neg_reg[k] ? acc_next - term : acc_next + term;
        end
    end

    // round half up, then saturate
    always_comb begin
        logic signed [ACC_WIDTH-1:0] shifted;
        shifted = (acc_reg + HALF) >>> FRAC_BITS;
        if (shifted > SAT_MAX) begin
            r_next  = data_t'(SAT_MAX[DATA_WIDTH-1:0]);
            ov_next = 1'b1;
        end else if (shifted < SAT_MIN) begin
            r_next  = data_t'(SAT_MIN[DATA_WIDTH-1:0]);
            ov_next = 1'b1;
        end else begin
            r_next  = data_t'(shifted[DATA_WIDTH-1:0]);
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                prod_reg[k] <= prod_next[k];
            end
            neg_reg <= op.neg;
            acc_reg <= acc_next;
            r_reg   <= r_next;
            ov_reg  <= ov_next;
        end
    end

    assign r  = r_reg;
    assign ov = ov_reg;

endmodule

// ===== src/qva_norm.sv =====
module qva_norm (
    input  logic           clk,
    input  logic           en,
    input  qva_pkg::quat_t a,
    output qva_pkg::quat_t r
);
    import qva_pkg::*;

    localparam logic [SQ_WIDTH-1:0] SQ_ONE = SQ_WIDTH'(1);

    logic [PROD_WIDTH-1:0] sq_reg  [NUM_LANES];
    logic [PROD_WIDTH-1:0] sq_next [NUM_LANES];
    quat_t                 a1_reg, a2_reg;
    logic [SQ_WIDTH-1:0]   s_reg, s_next;

    logic [SQ_WIDTH-1:0]   rt_num_reg  [SQ_STEPS];
    logic [SQ_WIDTH-1:0]   rt_num_next [SQ_STEPS];
    logic [SQ_WIDTH-1:0]   rt_res_reg  [SQ_STEPS];
    logic [SQ_WIDTH-1:0]   rt_res_next [SQ_STEPS];
    quat_t                 rt_a_reg    [SQ_STEPS];
    logic                  rt_zero_reg [SQ_STEPS];

    logic [NUM_WIDTH-1:0]  dv_rem_reg  [DIV_STEPS][NUM_LANES];
    logic [NUM_WIDTH-1:0]  dv_rem_next [DIV_STEPS][NUM_LANES];
    logic [DIV_STEPS-1:0]  dv_quo_reg  [DIV_STEPS][NUM_LANES];
    logic [DIV_STEPS-1:0]  dv_quo_next [DIV_STEPS][NUM_LANES];
    logic [ROOT_WIDTH-1:0] dv_m_reg    [DIV_STEPS];
    quat_t                 dv_a_reg    [DIV_STEPS];
    logic                  dv_zero_reg [DIV_STEPS];

    quat_t                 r_reg, r_next;

    always_comb begin
        logic signed [PROD_WIDTH-1:0] p;
        for (int i = 0; i < NUM_LANES; i++) begin
            p          = $signed(a[i]) * $signed(a[i]);
            sq_next[i] = p;
        end
    end

    always_comb begin
        s_next = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            s_next = s_next + SQ_WIDTH'(sq_reg[i]);
        end
    end

    // one root bit per stage, digit-by-digit method
    always_comb begin
        logic [SQ_WIDTH-1:0] num_in;
        logic [SQ_WIDTH-1:0] res_in;
        logic [SQ_WIDTH-1:0] bitv;
        logic [SQ_WIDTH-1:0] trial;
        for (int j = 0; j < SQ_STEPS; j++) begin
            if (j == 0) begin
                num_in = s_reg;
                res_in = '0;
            end else begin
                num_in = rt_num_reg[j-1];
                res_in = rt_res_reg[j-1];
            end
            bitv  = SQ_ONE << (2 * (SQ_STEPS - 1 - j));
            trial = res_in + bitv;
            if (num_in >= trial) begin
                rt_num_next[j] = num_in - trial;
                rt_res_next[j] = (res_in >> 1) + bitv;
            end else begin
                rt_num_next[j] = num_in;
                rt_res_next[j] = res_in >> 1;
            end
        end
    end

    // restoring divide, one quotient bit per stage, four lanes side by side
    always_comb begin
        logic [NUM_WIDTH-1:0]  rem_in;
        logic [DIV_STEPS-1:0]  quo_in;
        logic [ROOT_WIDTH-1:0] m_in;
        logic [NUM_WIDTH-1:0]  dsh;
        logic [DATA_WIDTH-1:0] mag;
        data_t                 av;
        for (int d = 0; d < DIV_STEPS; d++) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                av  = rt_a_reg[SQ_STEPS-1][i];
                mag = av[DATA_WIDTH-1] ? DATA_WIDTH'(-av) : DATA_WIDTH'(av);
                if (d == 0) begin
                    rem_in = NUM_WIDTH'(mag) << FRAC_BITS;
                    quo_in = '0;
                    m_in   = rt_res_reg[SQ_STEPS-1][ROOT_WIDTH-1:0];
                end else begin
                    rem_in = dv_rem_reg[d-1][i];
                    quo_in = dv_quo_reg[d-1][i];
                    m_in   = dv_m_reg[d-1];
                end
                dsh = NUM_WIDTH'(m_in) << (FRAC_BITS - d);
                if (rem_in >= dsh) begin
                    dv_rem_next[d][i] = rem_in - dsh;
                    dv_quo_next[d][i] = quo_in | (DIV_STEPS'(1) << (FRAC_BITS - d));
                end else begin
                    dv_rem_next[d][i] = rem_in;
                    dv_quo_next[d][i] = quo_in;
                end
            end
        end
    end

    // round to nearest, ties away from zero; zero magnitude passes a through
    always_comb begin
        logic [REM2_WIDTH-1:0] rem2;
        logic [QUO_WIDTH-1:0]  quo_r;
        logic [DATA_WIDTH-1:0] qv;
        data_t                 av;
        for (int i = 0; i < NUM_LANES; i++) begin
            rem2  = {dv_rem_reg[DIV_STEPS-1][i], 1'b0};
            quo_r = QUO_WIDTH'(dv_quo_reg[DIV_STEPS-1][i]);
            if (rem2 >= REM2_WIDTH'(dv_m_reg[DIV_STEPS-1])) begin
                quo_r = quo_r + QUO_WIDTH'(1);
            end
            qv = DATA_WIDTH'(quo_r);
            av = dv_a_reg[DIV_STEPS-1][i];
            if (dv_zero_reg[DIV_STEPS-1]) begin
                r_next[i] = av;
            end else if (av[DATA_WIDTH-1]) begin
                r_next[i] = data_t'(-qv);
            end else begin
                r_next[i] = data_t'(qv);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                sq_reg[i] <= sq_next[i];
            end
            a1_reg <= a;
            s_reg  <= s_next;
            a2_reg <= a1_reg;

            for (int j = 0; j < SQ_STEPS; j++) begin
                rt_num_reg[j] <= rt_num_next[j];
                rt_res_reg[j] <= rt_res_next[j];
            end
            rt_a_reg[0]    <= a2_reg;
            rt_zero_reg[0] <= (s_reg <= ZERO_THRESH);
            for (int j = 1; j < SQ_STEPS; j++) begin
                rt_a_reg[j]    <= rt_a_reg[j-1];
                rt_zero_reg[j] <= rt_zero_reg[j-1];
            end

            for (int d = 0; d < DIV_STEPS; d++) begin
                for (int i = 0; i < NUM_LANES; i++) begin
                    dv_rem_reg[d][i] <= dv_rem_next[d][i];
                    dv_quo_reg[d][i] <= dv_quo_next[d][i];
                end
            end
            dv_m_reg[0]    <= rt_res_reg[SQ_STEPS-1][ROOT_WIDTH-1:0];
            dv_a_reg[0]    <= rt_a_reg[SQ_STEPS-1];
            dv_zero_reg[0] <= rt_zero_reg[SQ_STEPS-1];
            for (int d = 1; d < DIV_STEPS; d++) begin
                dv_m_reg[d]    <= dv_m_reg[d-1];
                dv_a_reg[d]    <= dv_a_reg[d-1];
                dv_zero_reg[d] <= dv_zero_reg[d-1];
            end

            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

// ===== src/qva_checker.sv =====
`include "quaternion_vector_alu_unit_defines.svh"

module qva_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [qva_pkg::DATA_WIDTH-1:0] r_w,
    input logic [qva_pkg::DATA_WIDTH-1:0] r_x,
    input logic [qva_pkg::DATA_WIDTH-1:0] r_y,
    input logic [qva_pkg::DATA_WIDTH-1:0] r_z,
    input logic                           overflow
);

    // an empty output register always frees the input
    `QVA_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")

    // a waiting result holds the pipeline, so no new beat may enter
    `QVA_ASSERT_IMPLY(a_stall_blocks_input, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken while result stalled")

    // an offered beat is only refused while a result waits
    `QVA_ASSERT_IMPLY(a_refuse_only_on_stall, clk, rst_n, in_valid && !in_ready, out_valid && !out_ready, "operand refused without a stalled result")

    // a stalled result beat keeps its payload
    `QVA_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(r_w) && $stable(r_x) && $stable(r_y) && $stable(r_z) && $stable(overflow), "stalled result changed")

endmodule

bind quaternion_vector_alu_unit qva_checker u_qva_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .r_w       (result.r_w),
    .r_x       (result.r_x),
    .r_y       (result.r_y),
    .r_z       (result.r_z),
    .overflow  (result.overflow)
);
